// ===== rtl/wrls_pkg.sv =====
// ----------------------------------------------------------------------------
// Word RAM load/store unit package
// Shared widths, access codes, exception codes, state types and the queued
// operation record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package wrls_pkg;

  localparam int unsigned ADDR_W             = 14;
  localparam int unsigned WI_W               = ADDR_W - 2;
  localparam int unsigned DATA_W             = 32;
  localparam int unsigned FUNCT3_W           = 3;
  localparam int unsigned EXC_W              = 2;
  localparam int unsigned LANE_W             = 2;
  localparam int unsigned DEFAULT_WORD_DEPTH = 4096;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_STORE = 1'b1;

  localparam logic [FUNCT3_W-1:0] F3_BYTE   = 3'd0;
  localparam logic [FUNCT3_W-1:0] F3_HALF   = 3'd1;
  localparam logic [FUNCT3_W-1:0] F3_WORD   = 3'd2;
  localparam logic [FUNCT3_W-1:0] F3_BYTE_U = 3'd4;
  localparam logic [FUNCT3_W-1:0] F3_HALF_U = 3'd5;

  localparam logic [LANE_W-1:0] ALIGN_BYTE = 2'b00;
  localparam logic [LANE_W-1:0] ALIGN_HALF = 2'b01;
  localparam logic [LANE_W-1:0] ALIGN_WORD = 2'b11;

  typedef enum logic [EXC_W-1:0] {
    EXC_NONE             = 2'd0,
    EXC_LOAD_MISALIGNED  = 2'd1,
    EXC_STORE_MISALIGNED = 2'd2,
    EXC_ILLEGAL_WIDTH    = 2'd3
  } exc_code_t;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_REDUCE
  } front_state_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_EXEC
  } back_state_t;

  typedef struct packed {
    logic                is_store;
    logic [FUNCT3_W-1:0] width;
    exc_code_t           exc;
    logic [LANE_W-1:0]   lane;
    logic [WI_W-1:0]     idx;
    logic [DATA_W-1:0]   data;
  } wrls_op_t;

  typedef struct packed {
    logic     push;
    wrls_op_t op;
  } wrls_push_t;

  typedef struct packed {
    logic     valid;
    logic     full;
    wrls_op_t head;
  } wrls_qstat_t;

endpackage

// ===== rtl/wrls_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one load or store request per beat.
// ----------------------------------------------------------------------------
interface wrls_req_if
  import wrls_pkg::*;
();

  logic                valid;
  logic                ready;
  logic                mode;
  logic [FUNCT3_W-1:0] access_width;
  logic [ADDR_W-1:0]   byte_address;
  logic [DATA_W-1:0]   store_data;

  modport source (
    output valid, mode, access_width, byte_address, store_data,
    input  ready
  );

  modport sink (
    input  valid, mode, access_width, byte_address, store_data,
    output ready
  );

endinterface

// ===== rtl/wrls_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one load result and exception code per beat.
// ----------------------------------------------------------------------------
interface wrls_rsp_if
  import wrls_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [EXC_W-1:0]  exc_code;

  modport source (
    output valid, read_data, exc_code,
    input  ready
  );

  modport sink (
    input  valid, read_data, exc_code,
    output ready
  );

endinterface

// ===== rtl/wrls_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Accepts request beats, decodes width and alignment faults, wraps the word
// index into the RAM depth and pushes the decoded operation to the queue.
// ----------------------------------------------------------------------------
module wrls_front
  import wrls_pkg::*;
#(
  parameter int unsigned WORD_DEPTH = DEFAULT_WORD_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  wrls_req_if.sink    req,
  input  wrls_qstat_t qstat,
  output wrls_push_t  qpush
);

  localparam bit          POW2      = ((WORD_DEPTH & (WORD_DEPTH - 1)) == 0);
  localparam bit          NO_WRAP   = (WORD_DEPTH >= (2 ** WI_W));
  localparam bit          WRAP_ITER = !NO_WRAP && !POW2;
  localparam int unsigned RECIP_CL  = WRAP_ITER ? $clog2(WORD_DEPTH) : 1;
  localparam int unsigned RECIP_SH  = WI_W + RECIP_CL;
  localparam int unsigned RECIP_M_W = WI_W + 2;
  localparam int unsigned PROD_W    = WI_W + RECIP_M_W;
  localparam logic [WI_W-1:0]      IDX_MASK = WI_W'(WORD_DEPTH - 1);
  localparam logic [WI_W-1:0]      DIVISOR  = WI_W'(WORD_DEPTH);
  localparam logic [RECIP_M_W-1:0] RECIP_M  =
    RECIP_M_W'(((1 << RECIP_SH) + WORD_DEPTH - 1) / WORD_DEPTH);

  front_state_t      state_r, state_nxt;
  wrls_op_t          op_r, op_nxt;
  wrls_op_t          dec_op;
  logic [PROD_W-1:0] prod;
  logic [WI_W-1:0]   quot;
  logic [WI_W-1:0]   quot_d;
  logic [WI_W-1:0]   rem_nxt;
  logic              accept;
  logic [LANE_W-1:0] align_mask;
  logic              illegal;
  logic [WI_W-1:0]   word;

  always_comb begin
    illegal    = 1'b0;
    align_mask = ALIGN_BYTE;
    case (req.access_width) inside
      F3_BYTE, F3_BYTE_U: align_mask = ALIGN_BYTE;
      F3_HALF, F3_HALF_U: align_mask = ALIGN_HALF;
      F3_WORD:            align_mask = ALIGN_WORD;
      default:            illegal    = 1'b1;
    endcase
    if (req.mode == MODE_STORE && req.access_width > F3_WORD) begin
      illegal = 1'b1;
    end

    word            = req.byte_address[ADDR_W-1:LANE_W];
    dec_op.is_store = (req.mode == MODE_STORE);
    dec_op.width    = req.access_width;
    dec_op.lane     = req.byte_address[LANE_W-1:0];
    dec_op.data     = req.store_data;
    if (illegal) begin
      dec_op.exc = EXC_ILLEGAL_WIDTH;
    end else if ((req.byte_address[LANE_W-1:0] & align_mask) != '0) begin
      dec_op.exc = (req.mode == MODE_STORE) ? EXC_STORE_MISALIGNED : EXC_LOAD_MISALIGNED;
    end else begin
      dec_op.exc = EXC_NONE;
    end
    if (NO_WRAP || WRAP_ITER) begin
      dec_op.idx = word;
    end else begin
      dec_op.idx = word & IDX_MASK;
    end
  end

  always_comb begin
    prod    = PROD_W'(op_r.idx) * PROD_W'(RECIP_M);
    quot    = WI_W'(prod >> RECIP_SH);
    quot_d  = quot * DIVISOR;
    rem_nxt = op_r.idx - quot_d;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FRONT_IDLE: begin
        if (accept && WRAP_ITER) begin
          state_nxt = FRONT_REDUCE;
        end
      end
      FRONT_REDUCE: begin
        state_nxt = FRONT_IDLE;
      end
      default: state_nxt = FRONT_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    qpush.push = 1'b0;
    qpush.op   = dec_op;
    op_nxt     = op_r;
    unique case (state_r)
      FRONT_IDLE: begin
        req.ready  = !qstat.full;
        qpush.push = accept && !WRAP_ITER;
        op_nxt     = dec_op;
      end
      FRONT_REDUCE: begin
        qpush.op     = op_r;
        qpush.op.idx = rem_nxt;
        qpush.push   = 1'b1;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FRONT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

endmodule

// ===== rtl/wrls_queue.sv =====
// ----------------------------------------------------------------------------
// Operation queue
// Short FIFO of decoded operations between the front end and the back end.
// ----------------------------------------------------------------------------
module wrls_queue
  import wrls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  wrls_push_t  qpush,
  input  logic        pop,
  output wrls_qstat_t qstat
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  wrls_op_t          entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign do_push = qpush.push && (count_r != CNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign qstat.valid = (count_r != '0);
  assign qstat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign qstat.head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= qpush.op;
    end
  end

endmodule

// ===== rtl/wrls_back.sv =====
// ----------------------------------------------------------------------------
// Back end
// Holds the word RAM, reads the addressed word, merges store lanes or
// extends load lanes, writes back and registers the response beat.
// ----------------------------------------------------------------------------
module wrls_back
  import wrls_pkg::*;
#(
  parameter int unsigned WORD_DEPTH = DEFAULT_WORD_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  wrls_qstat_t qstat,
  output logic        pop,
  wrls_rsp_if.source  rsp
);

  localparam int unsigned IDX_W = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;

  logic [DATA_W-1:0] word_mem [WORD_DEPTH];
  back_state_t       state_r, state_nxt;
  wrls_op_t          op_r;
  logic [DATA_W-1:0] rd_data_r;
  logic [DATA_W-1:0] read_data_r;
  logic [EXC_W-1:0]  exc_code_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] lane_word;
  logic [DATA_W-1:0] lane_mask;
  logic [DATA_W-1:0] merged;
  logic [DATA_W-1:0] load_val;
  logic [4:0]        lane_shift;
  logic              fault;
  logic              do_write;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BACK_IDLE: begin
        if (pop) begin
          state_nxt = BACK_EXEC;
        end
      end
      BACK_EXEC: state_nxt = BACK_IDLE;
      default:   state_nxt = BACK_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    unique case (state_r)
      BACK_IDLE: pop = qstat.valid && (!out_valid_r || rsp.ready);
      BACK_EXEC: pop = 1'b0;
      default:   pop = 1'b0;
    endcase
  end

  always_comb begin
    lane_shift = {op_r.lane, 3'b000};
    lane_word  = rd_data_r >> lane_shift;
    fault      = (op_r.exc != EXC_NONE);

    case (op_r.width)
      F3_WORD: lane_mask = '1;
      F3_HALF: lane_mask = DATA_W'(16'hFFFF) << lane_shift;
      default: lane_mask = DATA_W'(8'hFF) << lane_shift;
    endcase
    merged = (rd_data_r & ~lane_mask) | ((op_r.data << lane_shift) & lane_mask);

    case (op_r.width)
      F3_WORD:   load_val = rd_data_r;
      F3_HALF_U: load_val = {16'h0000, lane_word[15:0]};
      F3_BYTE_U: load_val = {24'h000000, lane_word[7:0]};
      F3_HALF:   load_val = {{16{lane_word[15]}}, lane_word[15:0]};
      default:   load_val = {{24{lane_word[7]}}, lane_word[7:0]};
    endcase
    if (fault || op_r.is_store) begin
      load_val = '0;
    end

    do_write = (state_r == BACK_EXEC) && op_r.is_store && !fault;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= word_mem[IDX_W'(qstat.head.idx)];
    if (do_write) begin
      word_mem[IDX_W'(op_r.idx)] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r <= qstat.head;
    end
    if (state_r == BACK_EXEC) begin
      read_data_r <= load_val;
      exc_code_r  <= op_r.exc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BACK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BACK_EXEC) begin
        out_valid_r <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign rsp.valid     = out_valid_r;
  assign rsp.read_data = read_data_r;
  assign rsp.exc_code  = exc_code_r;

endmodule

// ===== rtl/word_ram_load_store_unit.sv =====
// ----------------------------------------------------------------------------
// Word RAM load/store unit
// RV32 byte, half and word loads and stores to a word-organized RAM, with
// misalignment and illegal-width reporting.
//
//   Channel  Direction  Beat contents
//   in_req   sink       mode, access_width, byte_address, store_data
//   out_rsp  source     read_data, exc_code
//
// The back end reads the RAM word, then merges or extends and writes back, and
// takes no new operation from the queue until it has finished the last one.
// A non-power-of-two WORD_DEPTH below 4096 adds a wrap state (FRONT_REDUCE)
// in the front end before the operation is queued.
// Reset clears control state only; RAM contents are undefined until written.
// A decoded-operation queue and the response register let each side stall.
// ----------------------------------------------------------------------------
module word_ram_load_store_unit
  import wrls_pkg::*;
#(
  parameter int unsigned WORD_DEPTH = DEFAULT_WORD_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  wrls_req_if.sink   in_req,
  wrls_rsp_if.source out_rsp
);

  wrls_push_t  qpush;
  wrls_qstat_t qstat;
  logic        pop;

  wrls_front #(
    .WORD_DEPTH (WORD_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (in_req),
    .qstat (qstat),
    .qpush (qpush)
  );

  wrls_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qpush (qpush),
    .pop   (pop),
    .qstat (qstat)
  );

  wrls_back #(
    .WORD_DEPTH (WORD_DEPTH)
  ) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .qstat (qstat),
    .pop   (pop),
    .rsp   (out_rsp)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Word RAM load/store unit testbench
// Sends RV32 loads and stores over the request channel and checks every
// response beat against a local model of the word RAM. Directed tests cover
// the word, half and byte lanes, sign extension, misalignment and illegal
// width codes. Random traffic then follows under four idling profiles. Loads
// and sub-word stores are steered to words already written by a word store.
// ----------------------------------------------------------------------------
module tb_top;
  import wrls_pkg::*;

  localparam int unsigned WORD_DEPTH       = DEFAULT_WORD_DEPTH;
  localparam int unsigned RANDOM_PER_PHASE = 256;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned MAX_REPORTS      = 10;

  localparam logic [FUNCT3_W-1:0] F3_RES_3 = 3'd3;
  localparam logic [FUNCT3_W-1:0] F3_RES_6 = 3'd6;
  localparam logic [FUNCT3_W-1:0] F3_RES_7 = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    exc_code_t         exc;
  } lsu_rsp_t;

  logic clk;
  logic rst_n;

  wrls_req_if req_if ();
  wrls_rsp_if rsp_if ();

  word_ram_load_store_unit #(
    .WORD_DEPTH(WORD_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  logic [DATA_W-1:0] ram_image [WORD_DEPTH];
  bit                word_written [WORD_DEPTH];
  int unsigned       written_words[$];
  lsu_rsp_t          pending_rsp[$];

  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  int unsigned load_count    = 0;
  int unsigned store_count   = 0;
  int unsigned fault_count   = 0;
  int unsigned error_count   = 0;
  int unsigned idle_cycles   = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int unsigned word_of(input logic [ADDR_W-1:0] addr);
    return (int'(addr) >> 2) % WORD_DEPTH;
  endfunction

  function automatic exc_code_t access_fault(input logic is_store,
                                             input logic [FUNCT3_W-1:0] f3,
                                             input logic [ADDR_W-1:0] addr);
    logic [LANE_W-1:0] amask;
    amask = ALIGN_BYTE;
    case (f3)
      F3_BYTE, F3_BYTE_U: amask = ALIGN_BYTE;
      F3_HALF, F3_HALF_U: amask = ALIGN_HALF;
      F3_WORD:            amask = ALIGN_WORD;
      default:            return EXC_ILLEGAL_WIDTH;
    endcase
    if (is_store == MODE_STORE && f3 > F3_WORD) return EXC_ILLEGAL_WIDTH;
    if ((addr[LANE_W-1:0] & amask) != '0) begin
      return (is_store == MODE_STORE) ? EXC_STORE_MISALIGNED : EXC_LOAD_MISALIGNED;
    end
    return EXC_NONE;
  endfunction

  // Applies one access to the RAM image and returns the response it causes.
  function automatic lsu_rsp_t predict_access(input logic is_store,
                                              input logic [FUNCT3_W-1:0] f3,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [DATA_W-1:0] data);
    lsu_rsp_t          r;
    int unsigned       idx;
    int unsigned       sh;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] lane;
    logic [DATA_W-1:0] m;
    r.read_data = '0;
    r.exc       = access_fault(is_store, f3, addr);
    idx         = word_of(addr);
    sh          = int'(addr[LANE_W-1:0]) * 8;
    if (r.exc == EXC_NONE) begin
      word = ram_image[idx];
      if (is_store == MODE_STORE) begin
        if (f3 == F3_WORD) begin
          word = data;
          if (!word_written[idx]) begin
            word_written[idx] = 1'b1;
            written_words.push_back(idx);
          end
        end else begin
          m    = (f3 == F3_HALF) ? 32'h0000_FFFF : 32'h0000_00FF;
          word = (word & ~(m << sh)) | ((data & m) << sh);
        end
        ram_image[idx] = word;
      end else begin
        lane = word >> sh;
        case (f3)
          F3_WORD:   r.read_data = word;
          F3_HALF_U: r.read_data = {16'h0000, lane[15:0]};
          F3_BYTE_U: r.read_data = {24'h000000, lane[7:0]};
          F3_HALF:   r.read_data = {{16{lane[15]}}, lane[15:0]};
          default:   r.read_data = {{24{lane[7]}}, lane[7:0]};
        endcase
      end
    end
    return r;
  endfunction

  task automatic send_access(input logic is_store, input logic [FUNCT3_W-1:0] f3,
                             input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
    lsu_rsp_t exp;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid        <= 1'b1;
    req_if.mode         <= is_store;
    req_if.access_width <= f3;
    req_if.byte_address <= addr;
    req_if.store_data   <= data;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    exp = predict_access(is_store, f3, addr, data);
    pending_rsp.push_back(exp);
    sent_count++;
    if (is_store == MODE_STORE) store_count++;
    else load_count++;
    if (exp.exc != EXC_NONE) fault_count++;
  endtask

  task automatic test_word_access();
    send_access(MODE_STORE, F3_WORD, 14'h0000, 32'h80FF_7F01);
    send_access(MODE_STORE, F3_WORD, 14'h3FFC, 32'hFFFF_FFFF);
    send_access(MODE_LOAD,  F3_WORD, 14'h0000, 32'h0000_0000);
    send_access(MODE_LOAD,  F3_WORD, 14'h3FFC, 32'hFFFF_FFFF);
  endtask

  task automatic test_subword_lanes();
    send_access(MODE_STORE, F3_BYTE,   14'h0001, 32'hAA55_55A5);
    send_access(MODE_STORE, F3_HALF,   14'h0002, 32'h1234_8001);
    send_access(MODE_LOAD,  F3_BYTE_U, 14'h0001, 32'h0000_0000);
    send_access(MODE_LOAD,  F3_HALF_U, 14'h0002, 32'h0000_0000);
    send_access(MODE_LOAD,  F3_BYTE_U, 14'h0003, 32'h0000_0000);
    send_access(MODE_STORE, F3_BYTE,   14'h3FFF, 32'h0000_0000);
    send_access(MODE_LOAD,  F3_WORD,   14'h3FFC, 32'h0000_0000);
  endtask

  task automatic test_sign_extension();
    send_access(MODE_LOAD, F3_BYTE, 14'h0001, 32'h0000_0000);
    send_access(MODE_LOAD, F3_BYTE, 14'h0000, 32'h0000_0000);
    send_access(MODE_LOAD, F3_HALF, 14'h0002, 32'h0000_0000);
    send_access(MODE_LOAD, F3_HALF, 14'h0000, 32'h0000_0000);
  endtask

  task automatic test_misaligned();
    send_access(MODE_LOAD,  F3_HALF, 14'h0001, 32'h0000_0000);
    send_access(MODE_LOAD,  F3_WORD, 14'h0002, 32'h0000_0000);
    send_access(MODE_STORE, F3_HALF, 14'h3FFF, 32'hFFFF_FFFF);
    send_access(MODE_STORE, F3_WORD, 14'h0003, 32'hDEAD_BEEF);
  endtask

  // A width code is checked before alignment, so some of these use odd addresses.
  task automatic test_illegal_width();
    send_access(MODE_LOAD,  F3_RES_3,  14'h0003, 32'h0000_0000);
    send_access(MODE_LOAD,  F3_RES_6,  14'h1555, 32'h0000_0000);
    send_access(MODE_LOAD,  F3_RES_7,  14'h3FFF, 32'h0000_0000);
    send_access(MODE_STORE, F3_BYTE_U, 14'h0000, 32'hFFFF_FFFF);
    send_access(MODE_STORE, F3_HALF_U, 14'h2001, 32'h1234_5678);
    send_access(MODE_STORE, F3_RES_7,  14'h0000, 32'h0000_0000);
  endtask

  task automatic test_random_traffic();
    int unsigned       phase_idle  [4];
    int unsigned       phase_stall [4];
    int unsigned       sel;
    int unsigned       last_word;
    logic              is_store;
    logic [FUNCT3_W-1:0] f3;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    phase_idle  = '{0, 54, 0, 35};
    phase_stall = '{0, 0, 54, 35};
    last_word   = 0;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      rsp_stall_pct = phase_stall[p];
      repeat (RANDOM_PER_PHASE) begin
        is_store = ($urandom_range(0, 1) == 1) ? MODE_STORE : MODE_LOAD;
        if ($urandom_range(0, 99) < 85) begin
          case ($urandom_range(0, 4))
            0:       f3 = F3_BYTE;
            1:       f3 = F3_HALF;
            2:       f3 = F3_WORD;
            3:       f3 = F3_BYTE_U;
            default: f3 = F3_HALF_U;
          endcase
        end else begin
          f3 = FUNCT3_W'($urandom_range(0, 7));
        end
        sel = $urandom_range(0, 99);
        if (sel < 35 || written_words.size() == 0) begin
          addr = ADDR_W'($urandom_range(0, 16383));
        end else if (sel < 55) begin
          addr = ADDR_W'((last_word << 2) | $urandom_range(0, 3));
        end else begin
          addr = ADDR_W'((written_words[$urandom_range(0, written_words.size() - 1)] << 2)
                         | $urandom_range(0, 3));
        end
        // Loads and sub-word stores to words that no word store has written yet are redirected.
        if (access_fault(is_store, f3, addr) == EXC_NONE &&
            !(is_store == MODE_STORE && f3 == F3_WORD) && !word_written[word_of(addr)]) begin
          if (written_words.size() == 0) begin
            is_store               = MODE_STORE;
            f3                     = F3_WORD;
            addr[LANE_W-1:0]       = '0;
          end else begin
            addr = ADDR_W'((written_words[$urandom_range(0, written_words.size() - 1)] << 2)
                           | addr[LANE_W-1:0]);
          end
        end
        sel = $urandom_range(0, 99);
        if (sel < 10) data = '0;
        else if (sel < 20) data = '1;
        else data = $urandom();
        last_word = word_of(addr);
        send_access(is_store, f3, addr, data);
      end
    end
  endtask

  always @(negedge clk) begin
    rsp_if.ready <= !(rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct);
  end

  always @(posedge clk) begin
    lsu_rsp_t exp;
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("ERROR: unexpected response beat: data %h exc %0d",
                   rsp_if.read_data, rsp_if.exc_code);
        end
      end else begin
        exp = pending_rsp.pop_front();
        if (rsp_if.read_data !== exp.read_data || rsp_if.exc_code !== exp.exc) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("ERROR: response %0d: expected data %h exc %0d, got data %h exc %0d",
                     checked_count, exp.read_data, exp.exc,
                     rsp_if.read_data, rsp_if.exc_code);
          end
        end
        checked_count++;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d responses outstanding", pending_rsp.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.mode         = MODE_LOAD;
    req_if.access_width = F3_WORD;
    req_if.byte_address = '0;
    req_if.store_data   = '0;
    rsp_if.ready        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_word_access();
    test_subword_lanes();
    test_sign_extension();
    test_misaligned();
    test_illegal_width();
    test_random_traffic();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d accesses (%0d loads, %0d stores, %0d faulting), checked %0d responses.",
             sent_count, load_count, store_count, fault_count, checked_count);
    $display("Word stores initialized %0d distinct RAM words; random traffic ran under four idling profiles.",
             written_words.size());
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wrls_pkg.sv
rtl/wrls_req_if.sv
rtl/wrls_rsp_if.sv
rtl/wrls_front.sv
rtl/wrls_queue.sv
rtl/wrls_back.sv
rtl/word_ram_load_store_unit.sv
bench/tb_top.sv
